// ----- src/gbi_pkg.sv -----
// ----------------------------------------------------------------------------
// Gravity body integrator package
// Shared widths, command codes, channel payload types and the 48-bit
// saturation helper.
// ----------------------------------------------------------------------------
package gbi_pkg;

  localparam int unsigned POS_FRAC_DEF = 16;
  localparam int unsigned VEL_FRAC_DEF = 24;
  localparam int unsigned STATE_W      = 48;
  localparam int unsigned MASS_W       = 32;
  localparam int unsigned RAD_W        = 16;
  localparam int unsigned GC_W         = 16;

  localparam logic [GC_W-1:0] GC_RESET = 16'd3277;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_INFL  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_MOVE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [STATE_W-1:0] pos_x;
    logic [STATE_W-1:0] pos_y;
    logic [STATE_W-1:0] init_speed_x;
    logic [STATE_W-1:0] init_speed_y;
    logic [MASS_W-1:0]  mass;
    logic [RAD_W-1:0]   radius;
  } in_item_t;

  typedef struct packed {
    logic [STATE_W-1:0] out_pos_x;
    logic [STATE_W-1:0] out_pos_y;
    logic [STATE_W-1:0] out_speed_x;
    logic [STATE_W-1:0] out_speed_y;
    logic [STATE_W-1:0] out_accel_x;
    logic [STATE_W-1:0] out_accel_y;
  } out_item_t;

  typedef logic [GC_W-1:0] cfg_item_t;

  function automatic logic [STATE_W-1:0] sat48(input logic [STATE_W:0] v);
    logic [STATE_W-1:0] r;
    if (v[STATE_W] != v[STATE_W-1]) begin
      r = {v[STATE_W], {(STATE_W-1){~v[STATE_W]}}};
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- src/gbi_chan_if.sv -----
// ----------------------------------------------------------------------------
// Gravity body integrator channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface gbi_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/gravity_body_integrator_core.sv -----
// ----------------------------------------------------------------------------
// Gravity body integrator core
// One body in fixed point, updated by load, influence, clear and move items.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload      Transaction
//  in_chan   sink       in_item_t    one command item
//  out_chan  source     out_item_t   body state after each item
//  cfg_chan  sink       cfg_item_t   gravitational constant write
//
// Load and clear go straight to the output; move updates the speed and then the
// position. Influence runs the squares, square root, restoring divisions and
// bit-serial multiplications through one 99-bit adder, and stops after the
// squares when the bodies touch.
// Reset is synchronous and clears the body state and the constant to defaults.
// A stalled output holds the finished item; a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module gravity_body_integrator_core
  import gbi_pkg::*;
#(
  parameter int unsigned POS_FRAC_BITS = POS_FRAC_DEF,
  parameter int unsigned VEL_FRAC_BITS = VEL_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gbi_chan_if.sink    in_chan,
  gbi_chan_if.source  out_chan,
  gbi_chan_if.sink    cfg_chan
);

  localparam int unsigned GSH    = 2 * POS_FRAC_BITS + VEL_FRAC_BITS - 16;
  localparam int unsigned AN_W   = STATE_W + GSH;
  localparam int unsigned D_W    = STATE_W + 1;
  localparam int unsigned S_W    = 2 * D_W;
  localparam int unsigned ALU_W  = S_W + 1;
  localparam int unsigned T_FRAC = 32;
  localparam int unsigned T_W    = T_FRAC + 1;
  localparam int unsigned A_W    = STATE_W - 1;
  localparam int unsigned TN_W   = D_W + T_FRAC;
  localparam int unsigned NQ_W   = (AN_W > S_W) ? AN_W : S_W;
  localparam int unsigned IT_MAX = (AN_W > TN_W) ? AN_W : TN_W;
  localparam int unsigned CNT_W  = $clog2(IT_MAX + 1);
  localparam int unsigned RS_W   = RAD_W + 1 + POS_FRAC_BITS;
  localparam int unsigned VSH    = VEL_FRAC_BITS - POS_FRAC_BITS;
  localparam int unsigned SR_IT  = S_W / 2;

  typedef enum logic [14:0] {
    S_IDLE  = 15'h0001,
    S_DIFF  = 15'h0002,
    S_ABS   = 15'h0004,
    S_SQ    = 15'h0008,
    S_CHK   = 15'h0010,
    S_SQRT  = 15'h0020,
    S_DIVA  = 15'h0040,
    S_TSET  = 15'h0080,
    S_DIVT  = 15'h0100,
    S_MSET  = 15'h0200,
    S_MUL   = 15'h0400,
    S_APPLY = 15'h0800,
    S_MOVE1 = 15'h1000,
    S_MOVE2 = 15'h2000,
    S_FIN   = 15'h4000
  } state_t;

  state_t             state_r, state_nxt;
  logic [GC_W-1:0]    g_r, g_nxt;
  logic [STATE_W-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic [STATE_W-1:0] vx_r, vx_nxt, vy_r, vy_nxt;
  logic [STATE_W-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [RAD_W-1:0]   brad_r, brad_nxt;
  logic [STATE_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic [MASS_W-1:0]  mass_r, mass_nxt;
  logic [RAD_W-1:0]   rad_r, rad_nxt;
  logic [D_W-1:0]     dx_r, dx_nxt, dy_r, dy_nxt;
  logic [D_W-1:0]     ux_r, ux_nxt, uy_r, uy_nxt;
  logic               sgx_r, sgx_nxt, sgy_r, sgy_nxt;
  logic [2*RS_W-1:0]  rs2_r, rs2_nxt;
  logic [STATE_W-1:0] gm_r, gm_nxt;
  logic [S_W-1:0]     s_r, s_nxt;
  logic [ALU_W-1:0]   acc_r, acc_nxt;
  logic [S_W-1:0]     mc_r, mc_nxt;
  logic [D_W-1:0]     mp_r, mp_nxt;
  logic [NQ_W-1:0]    nq_r, nq_nxt;
  logic [D_W-1:0]     root_r, root_nxt;
  logic [A_W-1:0]     amag_r, amag_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               axis_r, axis_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;

  logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
  logic               alu_sub, alu_carry;
  logic [ALU_W:0]     alu_sum;
  logic [NQ_W-1:0]    nq_sh;
  logic [AN_W-1:0]    aq;
  logic [A_W-1:0]     aq_sat;
  logic               cnt_last;
  logic [D_W-1:0]     u_sel;
  logic               neg_sel;
  logic [A_W-1:0]     mag;
  logic [STATE_W-1:0] acc_sel, acc_upd;
  logic [STATE_W:0]   acc_ext;
  logic [RS_W-1:0]    rs;
  logic [STATE_W-1:0] vxs, vys;
  logic               in_fire;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    alu_a   = acc_r;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_SQ, S_MUL: begin
        alu_b = mp_r[0] ? ALU_W'(mc_r) : '0;
      end
      S_SQRT: begin
        alu_a   = ALU_W'({acc_r[D_W:0], nq_r[NQ_W-1 -: 2]});
        alu_b   = ALU_W'({root_r, 2'b01});
        alu_sub = 1'b1;
      end
      S_DIVA: begin
        alu_a   = {acc_r[ALU_W-2:0], nq_r[NQ_W-1]};
        alu_b   = ALU_W'(s_r);
        alu_sub = 1'b1;
      end
      S_DIVT: begin
        alu_a   = {acc_r[ALU_W-2:0], nq_r[NQ_W-1]};
        alu_b   = ALU_W'(root_r);
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = acc_r;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                     + (ALU_W+1)'(alu_sub);
  assign alu_carry = alu_sum[ALU_W];
  assign alu_res   = alu_sum[ALU_W-1:0];
  assign nq_sh     = {nq_r[NQ_W-2:0], alu_carry};
  assign aq        = nq_sh[AN_W-1:0];
  assign aq_sat    = (|aq[AN_W-1:A_W]) ? {A_W{1'b1}} : aq[A_W-1:0];
  assign cnt_last  = (cnt_r == CNT_W'(1));
  assign u_sel     = axis_r ? uy_r : ux_r;
  assign neg_sel   = axis_r ? sgy_r : sgx_r;
  assign mag       = acc_r[T_FRAC +: A_W];
  assign acc_sel   = axis_r ? ay_r : ax_r;
  assign acc_ext   = neg_sel ? ({acc_sel[STATE_W-1], acc_sel} + {2'b00, mag})
                             : ({acc_sel[STATE_W-1], acc_sel} - {2'b00, mag});
  assign acc_upd   = sat48(acc_ext);
  assign rs        = (RS_W'(brad_r) + RS_W'(rad_r)) << POS_FRAC_BITS;
  assign vxs       = STATE_W'($signed(vx_r) >>> VSH);
  assign vys       = STATE_W'($signed(vy_r) >>> VSH);

  always_comb begin
    state_nxt     = state_r;
    g_nxt         = g_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    vx_nxt        = vx_r;
    vy_nxt        = vy_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    brad_nxt      = brad_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    mass_nxt      = mass_r;
    rad_nxt       = rad_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    ux_nxt        = ux_r;
    uy_nxt        = uy_r;
    sgx_nxt       = sgx_r;
    sgy_nxt       = sgy_r;
    rs2_nxt       = rs2_r;
    gm_nxt        = gm_r;
    s_nxt         = s_r;
    acc_nxt       = acc_r;
    mc_nxt        = mc_r;
    mp_nxt        = mp_r;
    nq_nxt        = nq_r;
    root_nxt      = root_r;
    amag_nxt      = amag_r;
    cnt_nxt       = cnt_r;
    axis_nxt      = axis_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_chan.valid) begin
      g_nxt = cfg_chan.data;
    end
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_t'(in_chan.data.command))
            CMD_LOAD: begin
              bx_nxt    = in_chan.data.pos_x;
              by_nxt    = in_chan.data.pos_y;
              vx_nxt    = in_chan.data.init_speed_x;
              vy_nxt    = in_chan.data.init_speed_y;
              ax_nxt    = '0;
              ay_nxt    = '0;
              brad_nxt  = in_chan.data.radius;
              state_nxt = S_FIN;
            end
            CMD_INFL: begin
              ox_nxt    = in_chan.data.pos_x;
              oy_nxt    = in_chan.data.pos_y;
              mass_nxt  = in_chan.data.mass;
              rad_nxt   = in_chan.data.radius;
              state_nxt = S_DIFF;
            end
            CMD_CLEAR: begin
              ax_nxt    = '0;
              ay_nxt    = '0;
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_MOVE1;
            end
          endcase
        end
      end
      S_DIFF: begin
        dx_nxt    = {bx_r[STATE_W-1], bx_r} - {ox_r[STATE_W-1], ox_r};
        dy_nxt    = {by_r[STATE_W-1], by_r} - {oy_r[STATE_W-1], oy_r};
        rs2_nxt   = (2*RS_W)'(rs) * (2*RS_W)'(rs);
        gm_nxt    = STATE_W'(g_r) * STATE_W'(mass_r);
        state_nxt = S_ABS;
      end
      S_ABS: begin
        ux_nxt    = dx_r[D_W-1] ? (~dx_r + D_W'(1)) : dx_r;
        uy_nxt    = dy_r[D_W-1] ? (~dy_r + D_W'(1)) : dy_r;
        sgx_nxt   = dx_r[D_W-1];
        sgy_nxt   = dy_r[D_W-1];
        acc_nxt   = '0;
        mc_nxt    = S_W'(ux_nxt);
        mp_nxt    = ux_nxt;
        cnt_nxt   = CNT_W'(D_W);
        axis_nxt  = 1'b0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        acc_nxt = alu_res;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_last) begin
          if (!axis_r) begin
            mc_nxt   = S_W'(uy_r);
            mp_nxt   = uy_r;
            cnt_nxt  = CNT_W'(D_W);
            axis_nxt = 1'b1;
          end else begin
            axis_nxt  = 1'b0;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        s_nxt = acc_r[S_W-1:0];
        if (acc_r[S_W-1:0] > S_W'(rs2_r)) begin
          nq_nxt    = NQ_W'(acc_r[S_W-1:0]) << (NQ_W - S_W);
          acc_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = CNT_W'(SR_IT);
          state_nxt = S_SQRT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SQRT: begin
        acc_nxt  = alu_carry ? alu_res : alu_a;
        root_nxt = {root_r[D_W-2:0], alu_carry};
        nq_nxt   = nq_r << 2;
        cnt_nxt  = cnt_r - CNT_W'(1);
        if (cnt_last) begin
          nq_nxt    = NQ_W'(gm_r) << (NQ_W - STATE_W);
          acc_nxt   = '0;
          cnt_nxt   = CNT_W'(AN_W);
          state_nxt = S_DIVA;
        end
      end
      S_DIVA: begin
        acc_nxt = alu_carry ? alu_res : alu_a;
        nq_nxt  = nq_sh;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_last) begin
          amag_nxt  = aq_sat;
          state_nxt = S_TSET;
        end
      end
      S_TSET: begin
        nq_nxt    = NQ_W'(u_sel) << (NQ_W - D_W);
        acc_nxt   = '0;
        cnt_nxt   = CNT_W'(TN_W);
        state_nxt = S_DIVT;
      end
      S_DIVT: begin
        acc_nxt = alu_carry ? alu_res : alu_a;
        nq_nxt  = nq_sh;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_last) begin
          state_nxt = S_MSET;
        end
      end
      S_MSET: begin
        mp_nxt    = D_W'(nq_r[T_W-1:0]);
        mc_nxt    = S_W'(amag_r);
        acc_nxt   = '0;
        cnt_nxt   = CNT_W'(T_W);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        acc_nxt = alu_res;
        mc_nxt  = mc_r << 1;
        mp_nxt  = mp_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_last) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (!axis_r) begin
          ax_nxt    = acc_upd;
          axis_nxt  = 1'b1;
          state_nxt = S_TSET;
        end else begin
          ay_nxt    = acc_upd;
          axis_nxt  = 1'b0;
          state_nxt = S_FIN;
        end
      end
      S_MOVE1: begin
        vx_nxt    = sat48({vx_r[STATE_W-1], vx_r} + {ax_r[STATE_W-1], ax_r});
        vy_nxt    = sat48({vy_r[STATE_W-1], vy_r} + {ay_r[STATE_W-1], ay_r});
        state_nxt = S_MOVE2;
      end
      S_MOVE2: begin
        bx_nxt    = sat48({bx_r[STATE_W-1], bx_r} + {vxs[STATE_W-1], vxs});
        by_nxt    = sat48({by_r[STATE_W-1], by_r} + {vys[STATE_W-1], vys});
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_data_nxt.out_pos_x   = bx_r;
          out_data_nxt.out_pos_y   = by_r;
          out_data_nxt.out_speed_x = vx_r;
          out_data_nxt.out_speed_y = vy_r;
          out_data_nxt.out_accel_x = ax_r;
          out_data_nxt.out_accel_y = ay_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      g_r         <= GC_RESET;
      bx_r        <= '0;
      by_r        <= '0;
      vx_r        <= '0;
      vy_r        <= '0;
      ax_r        <= '0;
      ay_r        <= '0;
      brad_r      <= '0;
      cnt_r       <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      g_r         <= g_nxt;
      bx_r        <= bx_nxt;
      by_r        <= by_nxt;
      vx_r        <= vx_nxt;
      vy_r        <= vy_nxt;
      ax_r        <= ax_nxt;
      ay_r        <= ay_nxt;
      brad_r      <= brad_nxt;
      cnt_r       <= cnt_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    mass_r     <= mass_nxt;
    rad_r      <= rad_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    ux_r       <= ux_nxt;
    uy_r       <= uy_nxt;
    sgx_r      <= sgx_nxt;
    sgy_r      <= sgy_nxt;
    rs2_r      <= rs2_nxt;
    gm_r       <= gm_nxt;
    s_r        <= s_nxt;
    acc_r      <= acc_nxt;
    mc_r       <= mc_nxt;
    mp_r       <= mp_nxt;
    nq_r       <= nq_nxt;
    root_r     <= root_nxt;
    amag_r     <= amag_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
